// ===== hdl/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants of the command packet deframer: CRC parameters,
// packet geometry, status codes and the bundles that run between modules.
// ----------------------------------------------------------------------------
package cpd_pkg;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// packet geometry
	localparam int          BODY_LONG     = 22;
	localparam logic [4:0]  BODY_SHORT_B  = 5'd14;
	localparam logic [4:0]  BODY_LONG_B   = 5'd22;
	localparam logic [4:0]  COUNT_MAX     = 5'd31;

	// result status codes
	localparam logic [1:0]  STATUS_OK      = 2'd0;
	localparam logic [1:0]  STATUS_BAD_LEN = 2'd1;
	localparam logic [1:0]  STATUS_BAD_CRC = 2'd2;

	// one byte handed from the input stage to the deframer
	typedef struct packed {
		logic       fire;
		logic [7:0] data;
		logic       last;
		logic       format;
	} cpd_step_t;

	// committed packet fields
	typedef struct packed {
		logic [7:0]  version;
		logic [7:0]  command;
		logic [31:0] sequence_no;
		logic [31:0] timestamp;
		logic [31:0] confidence;
		logic [7:0]  intensity;
		logic [7:0]  digit_mask;
		logic [39:0] digit_angles;
		logic [7:0]  reserved_b;
		logic [15:0] checksum;
	} cpd_fields_t;

endpackage

// ===== hdl/cpd_if.sv =====
// ----------------------------------------------------------------------------
// cpd_in_if / cpd_out_if
// Valid/ready channels of the deframer: received bytes in, packet reports out.
// ----------------------------------------------------------------------------
interface cpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cpd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  version_out;
	logic [7:0]  command_code;
	logic [31:0] sequence_out;
	logic [31:0] timestamp_out;
	logic [31:0] confidence_bits;
	logic [7:0]  intensity_out;
	logic [7:0]  digit_mask_out;
	logic [39:0] digit_angles_out;
	logic [7:0]  reserved_out;
	logic [15:0] checksum_out;

	modport source (
		output valid, output status, output version_out, output command_code,
		output sequence_out, output timestamp_out, output confidence_bits,
		output intensity_out, output digit_mask_out, output digit_angles_out,
		output reserved_out, output checksum_out, input ready
	);
	modport sink (
		input valid, input status, input version_out, input command_code,
		input sequence_out, input timestamp_out, input confidence_bits,
		input intensity_out, input digit_mask_out, input digit_angles_out,
		input reserved_out, input checksum_out, output ready
	);
endinterface

// ===== hdl/cpd_crc16.sv =====
// ----------------------------------------------------------------------------
// cpd_crc16
// One byte of CRC-16/CCITT-FALSE, MSB first, as flat XOR logic.
// ----------------------------------------------------------------------------
module cpd_crc16 (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);
	import cpd_pkg::*;

	// eight shift steps, fully unrolled
	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

// ===== hdl/cpd_deframe.sv =====
// ----------------------------------------------------------------------------
// cpd_deframe
// Packet state: byte count, running CRC, received CRC, staging body and the
// last good (committed) fields. Gives the status of a packet at its end byte.
// ----------------------------------------------------------------------------
module cpd_deframe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpd_pkg::cpd_step_t   step,
	output logic [1:0]           status,
	output cpd_pkg::cpd_fields_t fields
);
	import cpd_pkg::*;

	logic [4:0]  count_q;
	logic [15:0] crc_q;
	logic [15:0] rx_crc_q;
	logic [7:0]  staging_q   [BODY_LONG];
	logic [7:0]  committed_q [BODY_LONG];
	logic [15:0] checksum_q;

	logic [4:0]  body;
	logic        in_body;
	logic        at_crc_lo;
	logic        at_crc_hi;
	logic [15:0] crc_step;
	logic [15:0] crc_next;
	logic [15:0] rx_crc_next;
	logic [4:0]  count_next;
	logic        commit;

	cpd_crc16 u_crc (
		.crc      (crc_q),
		.data     (step.data),
		.crc_next (crc_step)
	);

	// sort the byte by position
	always_comb begin
		body        = step.format ? BODY_LONG_B : BODY_SHORT_B;
		in_body     = count_q < body;
		at_crc_lo   = count_q == body;
		at_crc_hi   = count_q == body + 5'd1;
		crc_next    = in_body ? crc_step : crc_q;
		rx_crc_next = rx_crc_q;
		if (at_crc_lo) begin
			rx_crc_next[7:0] = step.data;
		end
		if (at_crc_hi) begin
			rx_crc_next[15:8] = step.data;
		end
		count_next = (count_q == COUNT_MAX) ? count_q : count_q + 5'd1;
	end

	// length first, then CRC
	always_comb begin
		if (count_next != body + 5'd2) begin
			status = STATUS_BAD_LEN;
		end else if (crc_next != rx_crc_next) begin
			status = STATUS_BAD_CRC;
		end else begin
			status = STATUS_OK;
		end
		commit = step.fire && step.last && (status == STATUS_OK);
	end

	// per-packet control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			crc_q    <= CRC_INIT;
			rx_crc_q <= '0;
		end else if (step.fire) begin
			if (step.last) begin
				count_q  <= '0;
				crc_q    <= CRC_INIT;
				rx_crc_q <= '0;
			end else begin
				count_q  <= count_next;
				crc_q    <= crc_next;
				rx_crc_q <= rx_crc_next;
			end
		end
	end

	// staging body, written at the current position
	always_ff @(posedge clk) begin
		for (int i = 0; i < BODY_LONG; i++) begin
			if (step.fire && in_body && count_q == 5'(i)) begin
				staging_q[i] <= step.data;
			end
		end
	end

	// committed fields: body bytes copied, tail cleared for the short format
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BODY_LONG; i++) begin
				committed_q[i] <= '0;
			end
			checksum_q <= '0;
		end else if (commit) begin
			for (int i = 0; i < BODY_LONG; i++) begin
				committed_q[i] <= (5'(i) < body) ? staging_q[i] : 8'h00;
			end
			checksum_q <= rx_crc_next;
		end
	end

	// little-endian field unpacking
	always_comb begin
		fields.version       = committed_q[0];
		fields.command       = committed_q[1];
		fields.sequence_no   = {committed_q[5], committed_q[4], committed_q[3],
			committed_q[2]};
		fields.timestamp     = {committed_q[9], committed_q[8], committed_q[7],
			committed_q[6]};
		fields.confidence    = {committed_q[13], committed_q[12], committed_q[11],
			committed_q[10]};
		fields.intensity     = committed_q[14];
		fields.digit_mask    = committed_q[15];
		fields.digit_angles  = {committed_q[20], committed_q[19], committed_q[18],
			committed_q[17], committed_q[16]};
		fields.reserved_b    = committed_q[21];
		fields.checksum      = checksum_q;
	end

endmodule

// ===== hdl/command_packet_deframer_crc_check.sv =====
// ----------------------------------------------------------------------------
// command_packet_deframer_crc_check
// Byte-stream packet deframer with CRC-16/CCITT-FALSE check and field unpack.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  rx_byte   | in  | valid / ready | data_byte, last_byte
//  report    | out | valid / ready | status and the last good packet fields
//  cfg       | in  | cfg_wr_en     | cfg_wr_data = packet_format
//
//  One byte per cycle while no end byte is held back. A byte is registered in
//  the input register, is processed into the packet state, and an end byte
//  loads the report register. Reset clears the packet state, committed
//  fields and the format (short). A full report register holds back only end
//  bytes; other bytes keep flowing while a report waits.
// ----------------------------------------------------------------------------
module command_packet_deframer_crc_check (
	input  logic      clk,
	input  logic      arst_n,
	cpd_in_if.sink    rx_byte,
	cpd_out_if.source report,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);
	import cpd_pkg::*;

	logic        format_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        res_valid_q;
	logic [1:0]  status_q;
	logic        advance;
	logic [1:0]  status;
	cpd_step_t   step;
	cpd_fields_t fields;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= 1'b0;
		end else if (cfg_wr_en) begin
			format_q <= cfg_wr_data;
		end
	end

	// input stage moves on unless an end byte meets a full report register
	assign advance       = valid_s1 && (!last_s1 || !res_valid_q || report.ready);
	assign rx_byte.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_byte.ready) begin
			valid_s1 <= rx_byte.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_byte.ready && rx_byte.valid) begin
			data_s1 <= rx_byte.data_byte;
			last_s1 <= rx_byte.last_byte;
		end
	end

	assign step = '{fire: advance, data: data_s1, last: last_s1, format: format_q};

	cpd_deframe u_deframe (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.status (status),
		.fields (fields)
	);

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (report.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status;
		end
	end

	// committed fields change only when a new report loads
	assign report.valid             = res_valid_q;
	assign report.status            = status_q;
	assign report.version_out       = fields.version;
	assign report.command_code      = fields.command;
	assign report.sequence_out      = fields.sequence_no;
	assign report.timestamp_out     = fields.timestamp;
	assign report.confidence_bits   = fields.confidence;
	assign report.intensity_out     = fields.intensity;
	assign report.digit_mask_out    = fields.digit_mask;
	assign report.digit_angles_out  = fields.digit_angles;
	assign report.reserved_out      = fields.reserved_b;
	assign report.checksum_out      = fields.checksum;

endmodule
